// File: hdl/rmds_pkg.sv
// Package for the running median deviation sum core.
// Holds shared types and constants; depends on nothing.
`default_nettype none
package rmds_pkg;
    localparam int unsigned DEV_BITS = 45;
    localparam int unsigned OUT_BITS = 44;
    typedef logic [DEV_BITS-1:0] t_dev;
endpackage
`default_nettype wire

// File: hdl/running_median_deviation_sum_core.sv
// Top level of the running median deviation sum core.
// Depends on rmds_pkg and rmds_heap.
`default_nettype none
// Channel | Direction | Fields
// sample  | in        | i_sample
// result  | out       | o_deviation_twice, o_store_full
// A push sifts the new key up the heap one level at a time; a pop moves the
// last entry to the root and sinks it one level at a time. The worst
// request, a pop and two pushes, runs its heap operations one after another,
// and no other request is taken while one is in progress.
// Reset clears counts, sums and control. The output register holds a
// result until taken; a new request waits until then.
module running_median_deviation_sum_core #(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [43:0]      o_deviation_twice,
    output logic             o_store_full
);
    import rmds_pkg::*;

    localparam int unsigned HALF = (CAPACITY + 1) / 2;
    localparam int unsigned AW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int unsigned CW = $clog2(HALF + 1);
    localparam int unsigned KB = SAMPLE_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP1  = 3'd1;
    localparam logic [2:0] S_W1   = 3'd2;
    localparam logic [2:0] S_OP2  = 3'd3;
    localparam logic [2:0] S_W2   = 3'd4;
    localparam logic [2:0] S_OP3  = 3'd5;
    localparam logic [2:0] S_W3   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // insertion cases
    localparam logic [2:0] C_LOW       = 3'd0;
    localparam logic [2:0] C_MID       = 3'd1;
    localparam logic [2:0] C_SWAP_UP   = 3'd2;
    localparam logic [2:0] C_HIGH      = 3'd3;
    localparam logic [2:0] C_SWAP_DOWN = 3'd4;

    logic [2:0] r_st;
    t_dev r_lsum, r_usum;
    logic signed [KB-1:0] r_x;
    logic [2:0] r_case;
    logic lo_push, lo_pop, up_push, up_pop;
    logic signed [KB-1:0] lo_key, up_key;
    logic lo_busy, up_busy;
    logic signed [KB-1:0] lo_top, up_top;
    logic [CW-1:0] lo_cnt, up_cnt;
    logic signed [KB-1:0] x_in;
    logic signed [KB-1:0] med, utop;
    logic signed [KB-1:0] r_m;
    logic [KB-1:0] r_d, r_e;

    rmds_heap #(.DEPTH(HALF), .KEY_BITS(KB), .AW(AW), .CW(CW)) u_lo (
        .i_clk, .i_rst_n, .i_push(lo_push), .i_pop(lo_pop), .i_key(lo_key),
        .o_busy(lo_busy), .o_top(lo_top), .o_count(lo_cnt));
    rmds_heap #(.DEPTH(HALF), .KEY_BITS(KB), .AW(AW), .CW(CW)) u_up (
        .i_clk, .i_rst_n, .i_push(up_push), .i_pop(up_pop), .i_key(up_key),
        .o_busy(up_busy), .o_top(up_top), .o_count(up_cnt));

    assign x_in = KB'($signed(i_sample[SAMPLE_BITS-1:0]));
    assign med  = -lo_top;
    assign utop = up_top;
    assign o_ready = (r_st == S_IDLE) && !o_valid;

    // Heap operations per case: low side and middle push the lower heap; high side
    // pushes the upper; a swap up moves the upper top to the lower heap, a swap
    // down the old median to the upper; the sample goes where the moved key was.
    always_comb begin
        lo_push = 1'b0; lo_pop = 1'b0; up_push = 1'b0; up_pop = 1'b0;
        lo_key = -r_x; up_key = r_x;
        unique case (r_st)
            S_OP1: unique case (r_case) inside
                C_LOW, C_MID: lo_push = 1'b1;
                C_SWAP_UP: up_pop = 1'b1;
                C_HIGH: up_push = 1'b1;
                default: lo_pop = 1'b1;
            endcase
            S_OP2: unique case (r_case)
                C_SWAP_UP: begin lo_push = 1'b1; lo_key = -r_m; end
                C_SWAP_DOWN: lo_push = 1'b1;
                default: ;
            endcase
            S_OP3: unique case (r_case)
                C_SWAP_UP: up_push = 1'b1;
                C_SWAP_DOWN: begin up_push = 1'b1; up_key = r_m; end
                default: ;
            endcase
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_lsum <= '0;
            r_usum <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                // classify the request and hold the distances it needs
                S_IDLE: if (i_valid && o_ready) begin
                    r_x <= x_in;
                    r_d <= '0;
                    r_e <= '0;
                    o_store_full <= (32'(lo_cnt) + 32'(up_cnt) >= CAPACITY);
                    if (32'(lo_cnt) + 32'(up_cnt) >= CAPACITY) r_st <= S_OUT;
                    else begin
                        r_st <= S_OP1;
                        if (lo_cnt == up_cnt) begin
                            if (lo_cnt == '0 || med >= x_in) r_case <= C_LOW;
                            else if (up_cnt == '0 || utop >= x_in) begin
                                r_case <= C_MID;
                                r_d <= $unsigned(x_in - med);
                            end else begin
                                r_case <= C_SWAP_UP;
                                r_m <= utop;
                                r_d <= $unsigned(utop - med);
                                r_e <= $unsigned(x_in - utop);
                            end
                        end else if (x_in >= med) begin
                            r_case <= C_HIGH;
                            r_e <= $unsigned(x_in - med);
                        end else begin
                            r_case <= C_SWAP_DOWN;
                            r_m <= med;
                        end
                    end
                end
                // counts still show the state before this request
                S_OP1: begin
                    r_lsum <= r_lsum + t_dev'(lo_cnt * r_d);
                    r_usum <= r_usum + t_dev'(r_e) - t_dev'(up_cnt * r_d);
                    r_st <= S_W1;
                end
                S_W1: if (!lo_busy && !up_busy) begin
                    if (r_case == C_LOW) r_lsum <= r_lsum + t_dev'(med - r_x);
                    r_st <= (r_case == C_SWAP_UP || r_case == C_SWAP_DOWN) ? S_OP2 : S_OUT;
                end
                S_OP2: r_st <= S_W2;
                S_W2: if (!lo_busy) begin
                    if (r_case == C_SWAP_DOWN) begin
                        r_d <= $unsigned(r_m - med);
                        r_e <= $unsigned(med - r_x);
                    end
                    r_st <= S_OP3;
                end
                S_OP3: begin
                    if (r_case == C_SWAP_DOWN) begin
                        r_lsum <= r_lsum - t_dev'((lo_cnt - CW'(1)) * r_d) + t_dev'(r_e);
                        r_usum <= r_usum + t_dev'((up_cnt + CW'(1)) * r_d);
                    end
                    r_st <= S_W3;
                end
                S_W3: if (!up_busy) r_st <= S_OUT;
                S_OUT: if (!o_valid) begin
                    o_valid <= 1'b1;
                    o_deviation_twice <= OUT_BITS'((r_lsum + r_usum) << 1);
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/rmds_heap.sv
// One heap in a synchronous memory: push and pop by sift steps, one read a cycle.
// Keys are signed; smaller key is nearer the root. Depends on rmds_pkg.
`default_nettype none
module rmds_heap #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned KEY_BITS = 33,
    parameter int unsigned AW = 9,
    parameter int unsigned CW = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_pop,
    input  wire logic signed [KEY_BITS-1:0] i_key,
    output logic                            o_busy,
    output logic signed [KEY_BITS-1:0]      o_top,
    output logic [CW-1:0]                   o_count
);
    import rmds_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUP   = 3'd1;
    localparam logic [2:0] S_PDN_L = 3'd2;
    localparam logic [2:0] S_PDN_R = 3'd3;
    localparam logic [2:0] S_PDN_C = 3'd4;
    localparam logic [2:0] S_PUP_C = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;

    logic signed [KEY_BITS-1:0] mem [DEPTH];
    logic signed [KEY_BITS-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic signed [KEY_BITS-1:0] wd;

    logic [2:0] r_st;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_pos;
    logic signed [KEY_BITS-1:0] r_key, r_top, r_lkey;
    logic [CW:0] lidx;
    logic [CW:0] ridx;
    logic [AW-1:0] par;

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[rd_addr];
    end

    assign par  = (r_pos - AW'(1)) >> 1;
    assign lidx = (CW+1)'({r_pos, 1'b1});
    assign ridx = lidx + (CW+1)'(1);

    always_comb begin
        rd_addr = par;
        we = 1'b0; wa = r_pos; wd = r_key;
        unique case (r_st)
            S_IDLE:  rd_addr = AW'(r_cnt - CW'(1));
            S_PUP:   rd_addr = par;
            S_LAST:  rd_addr = AW'(r_cnt - CW'(1));
            S_PDN_L: rd_addr = AW'(lidx);
            S_PDN_R: rd_addr = AW'(ridx);
            S_PDN_C: rd_addr = AW'(lidx);
            S_PUP_C: begin
                if (r_rd > r_key && r_pos != '0) begin
                    we = 1'b1; wa = r_pos; wd = r_rd;
                end else begin
                    we = 1'b1; wa = r_pos; wd = r_key;
                end
            end
            default: ;
        endcase
        if (r_st == S_PDN_C) begin
            // decide with left in r_lkey, right in r_rd
            we = 1'b1; wa = r_pos; wd = r_key;
            if (lidx < (CW+1)'(r_cnt) && r_lkey < r_key &&
                !(ridx < (CW+1)'(r_cnt) && r_rd < r_lkey)) begin
                wd = r_lkey;
            end else if (ridx < (CW+1)'(r_cnt) && r_rd < r_key) begin
                wd = r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_push) begin
                        r_key <= i_key;
                        r_pos <= AW'(r_cnt);
                        if (r_cnt == '0 || i_key < r_top) r_top <= i_key;
                        r_cnt <= r_cnt + CW'(1);
                        r_st <= S_PUP;
                    end else if (i_pop) begin
                        r_cnt <= r_cnt - CW'(1);
                        r_pos <= '0;
                        r_st <= S_LAST;
                    end
                end
                S_PUP: r_st <= S_PUP_C;
                S_PUP_C: begin
                    if (r_rd > r_key && r_pos != '0) begin
                        r_pos <= par;
                        r_st <= S_PUP;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                // the last entry is on the read port now; sift it down from the root
                S_LAST: begin
                    r_key <= r_rd;
                    r_st <= S_PDN_L;
                end
                S_PDN_L: r_st <= S_PDN_R;
                S_PDN_R: begin
                    r_lkey <= r_rd;
                    r_st <= S_PDN_C;
                end
                S_PDN_C: begin
                    if (lidx < (CW+1)'(r_cnt) && r_lkey < r_key &&
                        !(ridx < (CW+1)'(r_cnt) && r_rd < r_lkey)) begin
                        r_pos <= AW'(lidx);
                        r_st <= S_PDN_L;
                    end else if (ridx < (CW+1)'(r_cnt) && r_rd < r_key) begin
                        r_pos <= AW'(ridx);
                        r_st <= S_PDN_L;
                    end else begin
                        r_st <= S_IDLE;
                    end
                    if (r_pos == '0) begin
                        if (lidx < (CW+1)'(r_cnt) && r_lkey < r_key &&
                            !(ridx < (CW+1)'(r_cnt) && r_rd < r_lkey))
                            r_top <= r_lkey;
                        else if (ridx < (CW+1)'(r_cnt) && r_rd < r_key)
                            r_top <= r_rd;
                        else
                            r_top <= r_key;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_st != S_IDLE);
    assign o_top   = r_top;
    assign o_count = r_cnt;
endmodule
`default_nettype wire

// File: hdl/rmds_checker.sv
// Port checker for the running median deviation sum core, with its bind.
// Depends on the top level's ports only.
`default_nettype none
module rmds_checker (
    input wire logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, o_store_full
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("second request taken");
    a_nover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("request while result waits");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_store_full)) else $error("flag moved");
endmodule
bind running_median_deviation_sum_core rmds_checker u_chk (.*);
`default_nettype wire
